FILE: rtl/bmlpc_pkg.sv
// Shared types and constants for the button mode LED PWM controller.
`timescale 1ns / 1ps

package bmlpc_pkg;

    typedef struct packed {
        logic key_pressed;
        logic charger_present;
    } in_item_t;

    typedef struct packed {
        logic [3:0] led_levels;
        logic       charge_led;
        logic       pwm_enable;
        logic [7:0] pwm_duty;
        logic [2:0] mode;
    } out_item_t;

    typedef struct packed {
        logic [7:0] short_press_ticks;
        logic [7:0] long_press_ticks;
        logic [7:0] duty_limit;
        logic [7:0] led_period_ticks;
    } cfg_t;

    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_SHORT = 2'd1;
    localparam logic [1:0] EVT_LONG  = 2'd2;

    typedef struct packed {
        logic [1:0] evt;
        logic [7:0] press_count;
        logic       long_press_seen;
    } key_upd_t;

    localparam logic [7:0] REG_SHORT_PRESS = 8'd0;
    localparam logic [7:0] REG_LONG_PRESS  = 8'd1;
    localparam logic [7:0] REG_DUTY_LIMIT  = 8'd2;
    localparam logic [7:0] REG_LED_PERIOD  = 8'd3;

    localparam logic [7:0] SHORT_PRESS_RESET = 8'd8;
    localparam logic [7:0] LONG_PRESS_RESET  = 8'd200;
    localparam logic [7:0] DUTY_LIMIT_RESET  = 8'd120;
    localparam logic [7:0] LED_PERIOD_RESET  = 8'd50;

    localparam logic [7:0] PRESS_MAX   = 8'd255;
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_FIRST  = 3'd1;
    localparam logic [2:0] MODE_LAST   = 3'd4;
    localparam logic [2:0] INTRO_STEPS = 3'd4;

endpackage

FILE: rtl/bmlpc_key.sv
// Press counter update and short/long press classification for one tick.
`timescale 1ns / 1ps

module bmlpc_key (
    input  logic                key_pressed,
    input  logic [7:0]          press_count,
    input  logic                long_press_seen,
    input  logic [7:0]          short_press_ticks,
    input  logic [7:0]          long_press_ticks,
    output bmlpc_pkg::key_upd_t upd
);

    logic [7:0] count_inc;

    assign count_inc = (press_count < bmlpc_pkg::PRESS_MAX) ? press_count + 8'd1 : press_count;

    always_comb begin
        upd.evt             = bmlpc_pkg::EVT_NONE;
        upd.press_count     = 8'd0;
        upd.long_press_seen = long_press_seen;
        if (key_pressed) begin
            upd.press_count = count_inc;
            if (count_inc >= long_press_ticks) begin
                // saturate at the long threshold, fire once per hold
                upd.press_count = long_press_ticks;
                if (!long_press_seen) begin
                    upd.long_press_seen = 1'b1;
                    upd.evt             = bmlpc_pkg::EVT_LONG;
                end
            end
        end else if (press_count >= long_press_ticks) begin
            upd.long_press_seen = 1'b0;
        end else if (press_count >= short_press_ticks) begin
            upd.evt = bmlpc_pkg::EVT_SHORT;
        end
    end

endmodule

FILE: rtl/bmlpc_core.sv
// Controller state registers and the per-tick mode, LED and duty update.
`timescale 1ns / 1ps

module bmlpc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  bmlpc_pkg::in_item_t  item,
    input  bmlpc_pkg::cfg_t      cfg,
    output bmlpc_pkg::out_item_t result
);

    logic [7:0] press_count_reg, press_count_next;
    logic       long_seen_reg, long_seen_next;
    logic [2:0] mode_step_reg, mode_step_next;
    logic [2:0] intro_step_reg, intro_step_next;
    logic [7:0] led_phase_reg, led_phase_next;
    logic [7:0] duty_ramp_reg, duty_ramp_next;
    logic [3:0] led_reg, led_next;
    logic       pwm_on_reg, pwm_on_next;
    logic [7:0] duty_cmp_reg, duty_cmp_next;

    bmlpc_pkg::key_upd_t key_upd;
    logic [8:0]          phase_inc;
    logic [8:0]          ramp_inc;
    logic [7:0]          ramp_base;
    logic [7:0]          cmp_base;

    bmlpc_key u_key (
        .key_pressed       (item.key_pressed),
        .press_count       (press_count_reg),
        .long_press_seen   (long_seen_reg),
        .short_press_ticks (cfg.short_press_ticks),
        .long_press_ticks  (cfg.long_press_ticks),
        .upd               (key_upd)
    );

    assign phase_inc = {1'b0, led_phase_reg} + 9'd1;

    always_comb begin
        press_count_next = press_count_reg;
        long_seen_next   = long_seen_reg;
        mode_step_next   = mode_step_reg;
        intro_step_next  = intro_step_reg;
        led_next         = led_reg;
        pwm_on_next      = pwm_on_reg;
        ramp_base        = duty_ramp_reg;
        cmp_base         = duty_cmp_reg;

        led_phase_next = (phase_inc >= {1'b0, cfg.led_period_ticks}) ? 8'd0 : phase_inc[7:0];

        // key handling pauses while charging
        if (!item.charger_present) begin
            press_count_next = key_upd.press_count;
            long_seen_next   = key_upd.long_press_seen;
            if (key_upd.evt == bmlpc_pkg::EVT_SHORT && mode_step_reg != bmlpc_pkg::MODE_OFF) begin
                led_phase_next = 8'd0;
                mode_step_next = (mode_step_reg >= bmlpc_pkg::MODE_LAST) ?
                                 bmlpc_pkg::MODE_FIRST : mode_step_reg + 3'd1;
                pwm_on_next    = 1'b1;
                ramp_base      = 8'd1;
                cmp_base       = 8'd1;
            end else if (key_upd.evt == bmlpc_pkg::EVT_LONG) begin
                if (mode_step_reg != bmlpc_pkg::MODE_OFF) begin
                    mode_step_next = bmlpc_pkg::MODE_OFF;
                    pwm_on_next    = 1'b0;
                end else begin
                    mode_step_next  = bmlpc_pkg::MODE_FIRST;
                    intro_step_next = bmlpc_pkg::INTRO_STEPS;
                    led_phase_next  = 8'd0;
                    pwm_on_next     = 1'b1;
                    ramp_base       = 8'd1;
                    cmp_base        = 8'd1;
                end
            end
        end

        if (led_phase_next == 8'd0) begin
            if (intro_step_next != 3'd0) begin
                case (intro_step_next)
                    3'd4:    led_next = led_reg | 4'b0001;
                    3'd3:    led_next = led_reg | 4'b0010;
                    3'd2:    led_next = led_reg | 4'b0100;
                    3'd1:    led_next = led_reg | 4'b1000;
                    default: led_next = led_reg;
                endcase
                intro_step_next = intro_step_next - 3'd1;
            end else begin
                case (mode_step_next)
                    3'd0:    led_next = 4'b0000;
                    3'd1:    led_next = 4'b0001;
                    3'd2:    led_next = led_reg | 4'b0010;
                    3'd3:    led_next = led_reg | 4'b0100;
                    3'd4:    led_next = led_reg | 4'b1000;
                    default: led_next = led_reg;
                endcase
            end
        end

        // ramp toward the limit; compare follows only below it
        ramp_inc       = {1'b0, ramp_base} + 9'd1;
        duty_ramp_next = (ramp_inc > {1'b0, cfg.duty_limit}) ? cfg.duty_limit : ramp_inc[7:0];
        duty_cmp_next  = (duty_ramp_next < cfg.duty_limit) ? duty_ramp_next : cmp_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_count_reg <= 8'd0;
            long_seen_reg   <= 1'b0;
            mode_step_reg   <= bmlpc_pkg::MODE_OFF;
            intro_step_reg  <= 3'd0;
            led_phase_reg   <= 8'd0;
            duty_ramp_reg   <= 8'd0;
            led_reg         <= 4'b0000;
            pwm_on_reg      <= 1'b0;
            duty_cmp_reg    <= 8'd0;
        end else if (step) begin
            press_count_reg <= press_count_next;
            long_seen_reg   <= long_seen_next;
            mode_step_reg   <= mode_step_next;
            intro_step_reg  <= intro_step_next;
            led_phase_reg   <= led_phase_next;
            duty_ramp_reg   <= duty_ramp_next;
            led_reg         <= led_next;
            pwm_on_reg      <= pwm_on_next;
            duty_cmp_reg    <= duty_cmp_next;
        end
    end

    always_comb begin
        result.led_levels = led_next;
        result.charge_led = item.charger_present;
        result.pwm_enable = pwm_on_next;
        result.pwm_duty   = duty_cmp_next;
        result.mode       = mode_step_next;
    end

endmodule

FILE: rtl/button_mode_led_pwm_controller.sv
// Top level: config registers, tick channel handshake and result register.
//
// Usage: send one tick transaction per 10 ms on s_valid/s_ready carrying
// key and charger levels in s_item. Each tick yields exactly one result
// transaction on m_valid/m_ready with LED levels, charge LED, PWM enable,
// PWM duty compare and the current mode.
// The result is registered in the output register when the tick is
// accepted. Throughput: one tick per cycle; s_ready is high whenever the
// output register is empty or is being taken in the same cycle.
// When the receiver stalls, the result holds in the output register and
// s_ready drops until it is taken.
// Configuration: cfg_valid/cfg_ready, always ready; cfg_index selects
// short press ticks, long press ticks, duty limit, LED period (0..3);
// other indexes are ignored. Write only while idle.
// Reset (aresetn low, synchronous): mode off, LEDs off, PWM stopped, all
// counters zero, registers at 8, 200, 120 and 50, no result pending.
`timescale 1ns / 1ps

module button_mode_led_pwm_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bmlpc_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bmlpc_pkg::out_item_t m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_index,
    input  logic [7:0]           cfg_data
);

    bmlpc_pkg::cfg_t      cfg_reg;
    bmlpc_pkg::out_item_t result;
    bmlpc_pkg::out_item_t out_reg;
    logic                 out_valid_reg;
    logic                 step;

    assign cfg_ready = 1'b1;
    assign s_ready   = !out_valid_reg || m_ready;
    assign step      = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_press_ticks <= bmlpc_pkg::SHORT_PRESS_RESET;
            cfg_reg.long_press_ticks  <= bmlpc_pkg::LONG_PRESS_RESET;
            cfg_reg.duty_limit        <= bmlpc_pkg::DUTY_LIMIT_RESET;
            cfg_reg.led_period_ticks  <= bmlpc_pkg::LED_PERIOD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bmlpc_pkg::REG_SHORT_PRESS: cfg_reg.short_press_ticks <= cfg_data;
                bmlpc_pkg::REG_LONG_PRESS:  cfg_reg.long_press_ticks  <= cfg_data;
                bmlpc_pkg::REG_DUTY_LIMIT:  cfg_reg.duty_limit        <= cfg_data;
                bmlpc_pkg::REG_LED_PERIOD:  cfg_reg.led_period_ticks  <= cfg_data;
                default: ;
            endcase
        end
    end

    bmlpc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (s_item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until the downstream transaction completes
    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= result;
        end
    end

endmodule

FILE: tb/tb_button_mode_led_pwm_controller.sv
// Self-checking testbench for the button mode LED PWM controller.
`timescale 1ns / 1ps

module tb_button_mode_led_pwm_controller;

    localparam int         CLK_PERIOD   = 20;
    localparam int         RESET_CYCLES = 10;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         IDLE_CYCLES  = 3;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         RANDOM_TICKS = 900;
    localparam int         PHASE_TICKS  = 120;
    localparam logic [7:0] REG_UNMAPPED = 8'hFF;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    bmlpc_pkg::in_item_t   s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    bmlpc_pkg::out_item_t  m_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [7:0]            cfg_index = '0;
    logic [7:0]            cfg_data  = '0;

    button_mode_led_pwm_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the controller state
    bmlpc_pkg::cfg_t shadow_cfg;
    logic [7:0]      press_cnt;
    logic            long_seen;
    logic [2:0]      cur_mode;
    logic [2:0]      intro_left;
    logic [7:0]      phase_cnt;
    logic [7:0]      ramp;
    logic [3:0]      leds;
    logic            pwm_run;
    logic [7:0]      duty_cmp;

    bmlpc_pkg::out_item_t pending_status[$];

    int ticks_sent      = 0;
    int results_checked = 0;
    int failures        = 0;
    int reg_writes      = 0;
    int mode_changes    = 0;
    int burst_left      = 0;
    int cycle_count     = 0;
    int rx_cycle        = 0;
    int rx_style        = 0;

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_status.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: switch between always ready, random stalls and periodic stalls
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 128 == 0) begin
            rx_style <= $urandom_range(0, 2);
        end
        case (rx_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= (rx_cycle % 16 < 9);
        endcase
    end

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_results
        bmlpc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                failures++;
                $display("%0t: result expected none got %p", $time, m_item);
            end else begin
                want = pending_status.pop_front();
                results_checked++;
                report_field("led_levels", {4'd0, want.led_levels},
                             {4'd0, m_item.led_levels});
                report_field("charge_led", {7'd0, want.charge_led},
                             {7'd0, m_item.charge_led});
                report_field("pwm_enable", {7'd0, want.pwm_enable},
                             {7'd0, m_item.pwm_enable});
                report_field("pwm_duty", want.pwm_duty, m_item.pwm_duty);
                report_field("mode", {5'd0, want.mode}, {5'd0, m_item.mode});
            end
        end
    end

    task automatic clear_controller();
        shadow_cfg.short_press_ticks = bmlpc_pkg::SHORT_PRESS_RESET;
        shadow_cfg.long_press_ticks  = bmlpc_pkg::LONG_PRESS_RESET;
        shadow_cfg.duty_limit        = bmlpc_pkg::DUTY_LIMIT_RESET;
        shadow_cfg.led_period_ticks  = bmlpc_pkg::LED_PERIOD_RESET;
        press_cnt  = '0;
        long_seen  = 1'b0;
        cur_mode   = bmlpc_pkg::MODE_OFF;
        intro_left = '0;
        phase_cnt  = '0;
        ramp       = '0;
        leds       = '0;
        pwm_run    = 1'b0;
        duty_cmp   = '0;
    endtask

    task automatic restart_pwm();
        pwm_run  = 1'b1;
        duty_cmp = 8'd1;
        ramp     = 8'd1;
    endtask

    // Advance the shadow state by one tick and queue the status it yields
    task automatic advance_controller(input bmlpc_pkg::in_item_t tick);
        logic [8:0]           next_phase;
        logic [8:0]           next_ramp;
        logic [1:0]           key_evt;
        logic [2:0]           old_mode;
        bmlpc_pkg::out_item_t status;
        old_mode   = cur_mode;
        next_phase = {1'b0, phase_cnt} + 9'd1;
        if (next_phase >= {1'b0, shadow_cfg.led_period_ticks}) begin
            next_phase = '0;
        end
        phase_cnt = next_phase[7:0];

        if (!tick.charger_present) begin
            key_evt = bmlpc_pkg::EVT_NONE;
            if (tick.key_pressed) begin
                if (press_cnt != bmlpc_pkg::PRESS_MAX) begin
                    press_cnt = press_cnt + 8'd1;
                end
                if (press_cnt >= shadow_cfg.long_press_ticks) begin
                    press_cnt = shadow_cfg.long_press_ticks;
                    if (!long_seen) begin
                        long_seen = 1'b1;
                        key_evt   = bmlpc_pkg::EVT_LONG;
                    end
                end
            end else if (press_cnt >= shadow_cfg.long_press_ticks) begin
                press_cnt = '0;
                long_seen = 1'b0;
            end else if (press_cnt >= shadow_cfg.short_press_ticks) begin
                press_cnt = '0;
                key_evt   = bmlpc_pkg::EVT_SHORT;
            end else begin
                press_cnt = '0;
            end

            if (key_evt == bmlpc_pkg::EVT_SHORT && cur_mode != bmlpc_pkg::MODE_OFF) begin
                phase_cnt = '0;
                cur_mode  = (cur_mode >= bmlpc_pkg::MODE_LAST) ? bmlpc_pkg::MODE_FIRST
                                                               : cur_mode + 3'd1;
                restart_pwm();
            end else if (key_evt == bmlpc_pkg::EVT_LONG) begin
                if (cur_mode != bmlpc_pkg::MODE_OFF) begin
                    cur_mode = bmlpc_pkg::MODE_OFF;
                    pwm_run  = 1'b0;
                end else begin
                    cur_mode   = bmlpc_pkg::MODE_FIRST;
                    intro_left = bmlpc_pkg::INTRO_STEPS;
                    phase_cnt  = '0;
                    restart_pwm();
                end
            end
        end

        if (phase_cnt == '0) begin
            if (intro_left != '0) begin
                // intro lights LED1 first and LED4 last
                leds       = leds | (4'b0001 << (bmlpc_pkg::INTRO_STEPS - intro_left));
                intro_left = intro_left - 3'd1;
            end else if (cur_mode == bmlpc_pkg::MODE_OFF) begin
                leds = '0;
            end else if (cur_mode == bmlpc_pkg::MODE_FIRST) begin
                leds = 4'b0001;
            end else if (cur_mode <= bmlpc_pkg::MODE_LAST) begin
                leds = leds | (4'b0001 << (cur_mode - bmlpc_pkg::MODE_FIRST));
            end
        end

        next_ramp = {1'b0, ramp} + 9'd1;
        if (next_ramp > {1'b0, shadow_cfg.duty_limit}) begin
            next_ramp = {1'b0, shadow_cfg.duty_limit};
        end
        ramp = next_ramp[7:0];
        if (ramp < shadow_cfg.duty_limit) begin
            duty_cmp = ramp;
        end

        status.led_levels = leds;
        status.charge_led = tick.charger_present;
        status.pwm_enable = pwm_run;
        status.pwm_duty   = duty_cmp;
        status.mode       = cur_mode;
        pending_status.push_back(status);
        if (cur_mode != old_mode) begin
            mode_changes++;
        end
    endtask

    task automatic send_tick(input logic key, input logic chrg);
        bmlpc_pkg::in_item_t tick;
        int                  gap;
        tick.key_pressed     = key;
        tick.charger_present = chrg;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_item  <= tick;
        do @(posedge aclk); while (!s_ready);
        advance_controller(tick);
        ticks_sent++;
        burst_left--;
    endtask

    task automatic press_key(input int hold, input int rel);
        repeat (hold) send_tick(1'b1, 1'b0);
        repeat (rel) send_tick(1'b0, 1'b0);
    endtask

    // Drop valid, wait for every status to come back, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bmlpc_pkg::REG_SHORT_PRESS: shadow_cfg.short_press_ticks = data;
            bmlpc_pkg::REG_LONG_PRESS:  shadow_cfg.long_press_ticks  = data;
            bmlpc_pkg::REG_DUTY_LIMIT:  shadow_cfg.duty_limit        = data;
            bmlpc_pkg::REG_LED_PERIOD:  shadow_cfg.led_period_ticks  = data;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_config(input logic [7:0] short_t, input logic [7:0] long_t,
                              input logic [7:0] limit, input logic [7:0] period);
        write_reg(bmlpc_pkg::REG_SHORT_PRESS, short_t);
        write_reg(bmlpc_pkg::REG_LONG_PRESS, long_t);
        write_reg(bmlpc_pkg::REG_DUTY_LIMIT, limit);
        write_reg(bmlpc_pkg::REG_LED_PERIOD, period);
    endtask

    task automatic test_reset_state();
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    task automatic test_mode_cycle();
        set_config(8'd1, 8'd2, 8'd3, 8'd2);
        press_key(1, 1);                // short press while off is ignored
        press_key(3, 1);                // long press turns on, release clears the flag
        send_tick(1'b1, 1'b1);          // charger holds the press counter
        send_tick(1'b0, 1'b1);
        repeat (4) press_key(1, 1);     // modes 2, 3, 4 and back to 1
        press_key(2, 1);                // off; ramp keeps running
        send_tick(1'b0, 1'b0);
    endtask

    task automatic test_intro_abort();
        set_config(8'd1, 8'd2, 8'd255, 8'd3);
        press_key(2, 1);
        press_key(2, 1);                // off while the intro is still running
        repeat (6) send_tick(1'b0, 1'b0);
    endtask

    task automatic test_threshold_corners();
        set_config(8'd5, 8'd2, 8'd120, 8'd1);
        press_key(3, 1);                // short above long: long wins
        set_config(8'd0, 8'd0, 8'd0, 8'd0);
        press_key(1, 1);
        press_key(1, 1);
        send_tick(1'b0, 1'b0);
        write_reg(REG_UNMAPPED, 8'hA5);
        send_tick(1'b1, 1'b0);
    endtask

    task automatic test_random_ticks(input int budget);
        int stop_at;
        int phase_end;
        int phase_idx;
        int hold;
        int s_ticks;
        int l_ticks;
        int kind;
        stop_at   = ticks_sent + budget;
        phase_idx = 0;
        while (ticks_sent < stop_at) begin
            case (phase_idx)
                0: set_config(8'd1, 8'd1, 8'd1, 8'd1);
                1: set_config(8'd255, 8'd255, 8'd255, 8'd255);
                default: set_config(8'($urandom_range(1, 12)), 8'($urandom_range(2, 40)),
                                    8'($urandom_range(1, 255)), 8'($urandom_range(1, 10)));
            endcase
            s_ticks   = int'(shadow_cfg.short_press_ticks);
            l_ticks   = int'(shadow_cfg.long_press_ticks);
            phase_end = ticks_sent + PHASE_TICKS;
            while (ticks_sent < phase_end && ticks_sent < stop_at) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    repeat ($urandom_range(1, 6))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else if (kind == 1) begin
                    // charger arrives in the middle of a press
                    repeat ($urandom_range(1, l_ticks)) send_tick(1'b1, 1'b0);
                    repeat ($urandom_range(1, 5)) send_tick(1'($urandom_range(0, 1)), 1'b1);
                    press_key($urandom_range(0, l_ticks), 1);
                end else begin
                    case ($urandom_range(0, 3))
                        0:       hold = (s_ticks > 1) ? $urandom_range(1, s_ticks - 1) : 1;
                        1:       hold = s_ticks + $urandom_range(0, 2);
                        2:       hold = l_ticks + $urandom_range(0, 3);
                        default: hold = $urandom_range(1, l_ticks + 2);
                    endcase
                    press_key(hold, $urandom_range(1, 3));
                end
            end
            phase_idx++;
        end
    endtask

    initial begin
        clear_controller();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_mode_cycle();
        test_intro_abort();
        test_threshold_corners();
        test_random_ticks(RANDOM_TICKS);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d status results from %0d ticks over %0d register writes",
                 results_checked, ticks_sent, reg_writes);
        $display("Covered %0d mode changes, threshold and period extremes, sender gaps and stalls",
                 mode_changes);
        if (failures == 0 && pending_status.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: button_mode_led_pwm_controller.f
rtl/bmlpc_pkg.sv
rtl/bmlpc_key.sv
rtl/bmlpc_core.sv
rtl/button_mode_led_pwm_controller.sv
tb/tb_button_mode_led_pwm_controller.sv
